// ===== src/bgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared types and constants of the bilinear grid sampler.
// ----------------------------------------------------------------------------
package bgs_pkg;

  // Default grid dimension bound
  localparam int MAX_DIM_DEF = 64;

  // Width of a linear cell address before the store-depth wrap
  localparam int LIN_W = 14;

  // Queue between front and back
  localparam int QDEPTH = 8;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_BILINEAR = 2'd0;
  localparam logic [1:0] ST_BASE     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

  // Reset value of both dimensions
  localparam logic [6:0] DIM_RESET = 7'd64;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic        cmd;
    logic [1:0]  status;
    logic [16:0] fx;
    logic [16:0] fy;
    logic [95:0] entry;
  } bgs_item_t;

endpackage

// ===== src/bilinear_grid_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_unit
// Bilinear sampler over a grid of 3-component Q16.16 vectors.
// Throughput: one item per cycle while busy is low; a sample's result strobe
// follows its accept through the front pipeline, queue, store read and lerp stages.
// The result side cannot stall; busy rises only if the queue credit runs out.
// Synchronous active-low reset clears control and sets both dimensions to 64;
// the grid store has no reset and holds nothing defined until written.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_unit #(
  parameter int MAX_DIM = bgs_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [11:0]        in_entry_index,
  input  logic signed [31:0] in_entry_x,
  input  logic signed [31:0] in_entry_y,
  input  logic signed [31:0] in_entry_z,
  input  logic signed [17:0] in_u_coord,
  input  logic signed [17:0] in_v_coord,
  output logic               out_valid,
  output logic signed [31:0] out_sample_x,
  output logic signed [31:0] out_sample_y,
  output logic signed [31:0] out_sample_z,
  output logic [1:0]         out_sample_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = $bits(bgs_pkg::bgs_item_t);
  localparam int DW = IW + 4 * AW;
  localparam int CW = $clog2(bgs_pkg::QDEPTH + 1);

  logic [6:0] grid_width_r, grid_height_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= bgs_pkg::DIM_RESET;
      grid_height_r <= bgs_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bgs_pkg::CFG_GRID_WIDTH) begin
        grid_width_r <= cfg_data;
      end else if (cfg_index == bgs_pkg::CFG_GRID_HEIGHT) begin
        grid_height_r <= cfg_data;
      end
    end
  end

  logic               accept;
  logic               push;
  bgs_pkg::bgs_item_t push_item, pop_item;
  logic [4*AW-1:0]    push_addr, pop_addr;
  logic [2:0]         front_cnt;
  logic [DW-1:0]      q_dout;
  logic               q_empty;
  logic [CW-1:0]      q_cnt;

  // Hold off new items when queue credit is used up
  assign busy   = ((CW+1)'(front_cnt) + (CW+1)'(q_cnt)) >= (CW+1)'(bgs_pkg::QDEPTH);
  assign accept = start && !busy;

  bgs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry       ({in_entry_z, in_entry_y, in_entry_x}),
    .in_u_coord     (in_u_coord),
    .in_v_coord     (in_v_coord),
    .grid_width     (grid_width_r),
    .grid_height    (grid_height_r),
    .push           (push),
    .push_item      (push_item),
    .push_addr      (push_addr),
    .occupancy      (front_cnt)
  );

  bgs_queue #(.DW(DW), .DEPTH(bgs_pkg::QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({push_addr, push_item}),
    .pop   (!q_empty),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_cnt)
  );

  assign pop_item = q_dout[IW-1:0];
  assign pop_addr = q_dout[DW-1:IW];

  bgs_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop               (!q_empty),
    .item              (pop_item),
    .addr              (pop_addr),
    .out_valid         (out_valid),
    .out_sample_x      (out_sample_x),
    .out_sample_y      (out_sample_y),
    .out_sample_z      (out_sample_z),
    .out_sample_status (out_sample_status)
  );

endmodule

// ===== src/bgs_front.sv =====
// ----------------------------------------------------------------------------
// bgs_front
// Scales coordinates, splits cell and fraction, classifies the neighbors and
// forms the four wrapped store addresses.
// ----------------------------------------------------------------------------
module bgs_front #(
  parameter int MAX_DIM = bgs_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     in_command,
  input  logic [11:0]              in_entry_index,
  input  logic [95:0]              in_entry,
  input  logic signed [17:0]       in_u_coord,
  input  logic signed [17:0]       in_v_coord,
  input  logic [6:0]               grid_width,
  input  logic [6:0]               grid_height,
  output logic                     push,
  output bgs_pkg::bgs_item_t       push_item,
  output logic [4*$clog2(MAX_DIM*MAX_DIM)-1:0] push_addr,
  output logic [2:0]               occupancy
);

  localparam int  DEPTH = MAX_DIM * MAX_DIM;
  localparam int  AW    = $clog2(DEPTH);
  localparam int  LW    = bgs_pkg::LIN_W;
  localparam int  SH    = LW + AW;
  localparam longint MULC = ((64'd1 << SH) + DEPTH - 1) / DEPTH;
  localparam int  XW    = (AW > LW) ? AW : LW;
  localparam logic [SH:0]   MUL_K   = MULC[SH:0];
  localparam logic [XW-1:0] DEPTH_K = XW'(DEPTH);

  // Stage 1: captured item
  logic        s1_v_r;
  logic        s1_cmd_r;
  logic [11:0] s1_idx_r;
  logic [95:0] s1_ent_r;
  logic signed [17:0] s1_u_r, s1_v_coord_r;

  // Stage 2: scaled coordinates
  logic        s2_v_r;
  logic        s2_cmd_r;
  logic [11:0] s2_idx_r;
  logic [95:0] s2_ent_r;
  logic signed [25:0] s2_pu_r, s2_pv_r;

  // Stage 3: cell, fraction, class
  logic        s3_v_r;
  logic        s3_cmd_r;
  logic [11:0] s3_idx_r;
  logic [95:0] s3_ent_r;
  logic [6:0]  s3_col_r, s3_row_r;
  logic [16:0] s3_fx_r, s3_fy_r;
  logic [1:0]  s3_st_r;

  // Stage 4: linear base address
  logic        s4_v_r;
  logic        s4_cmd_r;
  logic [95:0] s4_ent_r;
  logic [16:0] s4_fx_r, s4_fy_r;
  logic [1:0]  s4_st_r;
  logic [LW-1:0] s4_lin_r;

  // Stage 5: lane addresses and quotients
  logic        s5_v_r;
  logic        s5_cmd_r;
  logic [95:0] s5_ent_r;
  logic [16:0] s5_fx_r, s5_fy_r;
  logic [1:0]  s5_st_r;
  logic [LW-1:0] s5_lane_r [4];
  logic [LW-1:0] s5_q_r [4];

  // Scale products
  logic signed [7:0]  wm1, hm1;
  logic signed [25:0] pu_nxt, pv_nxt;
  assign wm1    = $signed({1'b0, grid_width}) - 8'sd1;
  assign hm1    = $signed({1'b0, grid_height}) - 8'sd1;
  assign pu_nxt = wm1 * s1_u_r;
  assign pv_nxt = hm1 * s1_v_coord_r;

  // Split toward zero and classify
  logic        adj_u, adj_v;
  logic [9:0]  col, row;
  logic signed [10:0] coli, rowi, wi, hi;
  logic        base_ok, all_ok;
  logic [1:0]  st_nxt;
  always_comb begin
    adj_u   = s2_pu_r[25] & (|s2_pu_r[15:0]);
    adj_v   = s2_pv_r[25] & (|s2_pv_r[15:0]);
    col     = s2_pu_r[25:16] + {9'b0, adj_u};
    row     = s2_pv_r[25:16] + {9'b0, adj_v};
    coli    = $signed({col[9], col});
    rowi    = $signed({row[9], row});
    wi      = $signed({4'b0, grid_width});
    hi      = $signed({4'b0, grid_height});
    base_ok = !col[9] && (coli < wi) && !row[9] && (rowi < hi);
    all_ok  = base_ok && (coli + 11'sd1 < wi) && (rowi + 11'sd1 < hi);
    if (all_ok) begin
      st_nxt = bgs_pkg::ST_BILINEAR;
    end else if (base_ok) begin
      st_nxt = bgs_pkg::ST_BASE;
    end else begin
      st_nxt = bgs_pkg::ST_OUTSIDE;
    end
  end

  // Linear base address
  logic [LW-1:0] lin_nxt;
  always_comb begin
    if (s3_cmd_r == bgs_pkg::CMD_WRITE) begin
      lin_nxt = LW'(s3_idx_r);
    end else begin
      lin_nxt = ({7'b0, s3_row_r} * {7'b0, grid_width}) + {7'b0, s3_col_r};
    end
  end

  // Neighbor lanes and reciprocal quotients
  logic [LW-1:0]    lane_nxt [4];
  logic [SH+LW-1:0] qp [4];
  always_comb begin
    lane_nxt[0] = s4_lin_r;
    lane_nxt[1] = s4_lin_r + LW'(1);
    lane_nxt[2] = s4_lin_r + {7'b0, grid_width};
    lane_nxt[3] = s4_lin_r + {7'b0, grid_width} + LW'(1);
    for (int k = 0; k < 4; k++) begin
      qp[k] = (SH+LW)'(lane_nxt[k]) * (SH+LW)'(MUL_K);
    end
  end

  // Wrap remainders
  logic [XW-1:0] rem [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem[k] = XW'(s5_lane_r[k]) - XW'(XW'(s5_q_r[k]) * DEPTH_K);
      push_addr[k*AW +: AW] = rem[k][AW-1:0];
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= in_command;
      s1_idx_r     <= in_entry_index;
      s1_ent_r     <= in_entry;
      s1_u_r       <= in_u_coord;
      s1_v_coord_r <= in_v_coord;
    end
    s2_cmd_r <= s1_cmd_r;
    s2_idx_r <= s1_idx_r;
    s2_ent_r <= s1_ent_r;
    s2_pu_r  <= pu_nxt;
    s2_pv_r  <= pv_nxt;

    s3_cmd_r <= s2_cmd_r;
    s3_idx_r <= s2_idx_r;
    s3_ent_r <= s2_ent_r;
    s3_col_r <= col[6:0];
    s3_row_r <= row[6:0];
    s3_fx_r  <= {adj_u, s2_pu_r[15:0]};
    s3_fy_r  <= {adj_v, s2_pv_r[15:0]};
    s3_st_r  <= st_nxt;

    s4_cmd_r <= s3_cmd_r;
    s4_ent_r <= s3_ent_r;
    s4_fx_r  <= s3_fx_r;
    s4_fy_r  <= s3_fy_r;
    s4_st_r  <= s3_st_r;
    s4_lin_r <= lin_nxt;

    s5_cmd_r <= s4_cmd_r;
    s5_ent_r <= s4_ent_r;
    s5_fx_r  <= s4_fx_r;
    s5_fy_r  <= s4_fy_r;
    s5_st_r  <= s4_st_r;
    for (int k = 0; k < 4; k++) begin
      s5_lane_r[k] <= lane_nxt[k];
      s5_q_r[k]    <= qp[k][SH +: LW];
    end
  end

  // Hand over to the queue
  assign push             = s5_v_r;
  assign push_item.cmd    = s5_cmd_r;
  assign push_item.status = s5_st_r;
  assign push_item.fx     = s5_fx_r;
  assign push_item.fy     = s5_fy_r;
  assign push_item.entry  = s5_ent_r;

  assign occupancy = 3'({2'b0, s1_v_r} + {2'b0, s2_v_r} + {2'b0, s3_v_r}
                        + {2'b0, s4_v_r} + {2'b0, s5_v_r});

endmodule

// ===== src/bgs_queue.sv =====
// ----------------------------------------------------------------------------
// bgs_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bgs_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = bgs_pkg::QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DW-1:0]              din,
  input  logic                       pop,
  output logic [DW-1:0]              dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  // Store incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= bump(wp_r);
      end
      if (pop) begin
        rp_r <= bump(rp_r);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign dout  = slot_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// ===== src/bgs_back.sv =====
// ----------------------------------------------------------------------------
// bgs_back
// Grid store with two read-duplicated copies and the bilinear datapath.
// ----------------------------------------------------------------------------
module bgs_back #(
  parameter int MAX_DIM = bgs_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop,
  input  bgs_pkg::bgs_item_t       item,
  input  logic [4*$clog2(MAX_DIM*MAX_DIM)-1:0] addr,
  output logic                     out_valid,
  output logic signed [31:0]       out_sample_x,
  output logic signed [31:0]       out_sample_y,
  output logic signed [31:0]       out_sample_z,
  output logic [1:0]               out_sample_status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  // Two copies: one serves the base row, one the next row
  logic [95:0] mem_a [DEPTH];
  logic [95:0] mem_b [DEPTH];

  logic [95:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;
  logic        b0_v_r, b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, out_v_r;
  logic [1:0]  st_r [6];
  logic [16:0] fx_r [5];
  logic [16:0] fy_r [2];

  logic signed [31:0] c00_r [3][5];
  logic signed [32:0] dl_r [3], dr_r [3];
  logic signed [31:0] c10_b1_r [3], c10_b2_r [3];
  logic signed [49:0] pl_r [3], pr_r [3];
  logic signed [34:0] left_r [3], right_r [3];
  logic signed [34:0] left_b4_r [3], left_b5_r [3];
  logic signed [35:0] d2_r [3];
  logic signed [52:0] p2_r [3];
  logic signed [31:0] res_r [3];
  logic [1:0]         ost_r;

  // Write on write items; read the four corners unconditionally
  always_ff @(posedge clk) begin
    if (pop && item.cmd == bgs_pkg::CMD_WRITE) begin
      mem_a[addr[0*AW +: AW]] <= item.entry;
      mem_b[addr[0*AW +: AW]] <= item.entry;
    end
    rd_a0_r <= mem_a[addr[0*AW +: AW]];
    rd_a1_r <= mem_a[addr[1*AW +: AW]];
    rd_b0_r <= mem_b[addr[2*AW +: AW]];
    rd_b1_r <= mem_b[addr[3*AW +: AW]];
  end

  // Advance sample valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      b5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b0_v_r  <= pop && (item.cmd == bgs_pkg::CMD_SAMPLE);
      b1_v_r  <= b0_v_r;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      b5_v_r  <= b4_v_r;
      out_v_r <= b5_v_r;
    end
  end

  // Interpolation datapath
  logic signed [37:0] sum [3];
  logic signed [31:0] res_nxt [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = {{3{left_b5_r[k][34]}}, left_b5_r[k]}
             + {p2_r[k][52], p2_r[k][52:16]};
      if (sum[k] > 38'sd2147483647) begin
        res_nxt[k] = 32'sh7FFFFFFF;
      end else if (sum[k] < -38'sd2147483648) begin
        res_nxt[k] = 32'sh80000000;
      end else begin
        res_nxt[k] = sum[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Carry metadata
    st_r[0] <= item.status;
    fx_r[0] <= item.fx;
    fy_r[0] <= item.fy;
    for (int i = 1; i < 6; i++) begin
      st_r[i] <= st_r[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      fx_r[i] <= fx_r[i-1];
    end
    fy_r[1] <= fy_r[0];

    for (int k = 0; k < 3; k++) begin
      // Column differences along y
      c00_r[k][0] <= $signed(rd_a0_r[k*32 +: 32]);
      for (int i = 1; i < 5; i++) begin
        c00_r[k][i] <= c00_r[k][i-1];
      end
      dl_r[k] <= $signed({rd_b0_r[k*32+31], rd_b0_r[k*32 +: 32]})
               - $signed({rd_a0_r[k*32+31], rd_a0_r[k*32 +: 32]});
      dr_r[k] <= $signed({rd_b1_r[k*32+31], rd_b1_r[k*32 +: 32]})
               - $signed({rd_a1_r[k*32+31], rd_a1_r[k*32 +: 32]});
      c10_b1_r[k] <= $signed(rd_a1_r[k*32 +: 32]);

      // Scale by the y fraction
      pl_r[k]     <= dl_r[k] * $signed(fy_r[1]);
      pr_r[k]     <= dr_r[k] * $signed(fy_r[1]);
      c10_b2_r[k] <= c10_b1_r[k];

      // Finish the y lerps with a floor shift
      left_r[k]  <= {{3{c00_r[k][1][31]}}, c00_r[k][1]} + {pl_r[k][49], pl_r[k][49:16]};
      right_r[k] <= {{3{c10_b2_r[k][31]}}, c10_b2_r[k]} + {pr_r[k][49], pr_r[k][49:16]};

      // Difference along x
      d2_r[k]      <= {right_r[k][34], right_r[k]} - {left_r[k][34], left_r[k]};
      left_b4_r[k] <= left_r[k];

      // Scale by the x fraction
      p2_r[k]      <= d2_r[k] * $signed(fx_r[4]);
      left_b5_r[k] <= left_b4_r[k];

      // Select by status
      case (st_r[5])
        bgs_pkg::ST_BILINEAR: res_r[k] <= res_nxt[k];
        bgs_pkg::ST_BASE:     res_r[k] <= c00_r[k][4];
        default:              res_r[k] <= '0;
      endcase
    end
    ost_r <= st_r[5];
  end

  assign out_valid         = out_v_r;
  assign out_sample_x      = res_r[0];
  assign out_sample_y      = res_r[1];
  assign out_sample_z      = res_r[2];
  assign out_sample_status = ost_r;

endmodule
